// ===== rtl/arxbc_pkg.sv =====
// ----------------------------------------------------------------------------
// arxbc_pkg
// shared types, constants and round function of the 128-bit arx block cipher
// ----------------------------------------------------------------------------
package arxbc_pkg;

   localparam int unsigned WORD_BITS             = 32;
   localparam int unsigned KEY_PAIRS             = 6;
   localparam int unsigned KEY_PAIR_BITS         = 2 * WORD_BITS;
   localparam int unsigned CSR_INDEX_BITS        = 3;
   localparam int unsigned ROUNDS_PER_PERM       = 3;
   localparam int unsigned PERMUTATIONS_PER_HALF = 10;

   localparam int unsigned ROT_B [ROUNDS_PER_PERM] = '{1, 4, 8};
   localparam int unsigned ROT_C [ROUNDS_PER_PERM] = '{2, 8, 12};
   localparam int unsigned ROT_D [ROUNDS_PER_PERM] = '{3, 12, 16};

   typedef logic [WORD_BITS-1:0]     word_type;
   typedef logic [KEY_PAIR_BITS-1:0] key_pair_type;

   typedef struct packed {
      word_type d;
      word_type c;
      word_type b;
      word_type a;
   } block_type;

   function automatic word_type rotl32(word_type x, int unsigned n);
      return (x << n) | (x >> (WORD_BITS - n));
   endfunction

   function automatic block_type arx_round(block_type v, int unsigned sel);
      block_type r;
      word_type  a2;
      word_type  c2;
      a2  = v.a + v.b;
      c2  = v.c + v.d;
      r.a = a2;
      r.b = rotl32(v.b ^ c2, ROT_B[sel]);
      r.c = rotl32(c2, ROT_C[sel]);
      r.d = rotl32(v.d ^ a2, ROT_D[sel]);
      return r;
   endfunction

endpackage

// ===== rtl/arx_block_cipher_128_encrypt_top.sv =====
// ----------------------------------------------------------------------------
// arx_block_cipher_128_encrypt_top
// 128-bit arx block encryption under a 384-bit key, fully pipelined
// ----------------------------------------------------------------------------
// Takes one 128-bit block per cycle unless rsp_tready holds it back: every
// arx round has a register stage of its own, and each of the three key xors
// takes one more stage. Each stage stalls only when it is full and the next
// one cannot take its block, so bubbles close up and a waiting result blocks
// new requests only once every stage is full. The user must write the key
// through the csr port only while no request is in flight; the block does
// not enforce this. Writes to an index above five are dropped.
module arx_block_cipher_128_encrypt_top
   import arxbc_pkg::*;
#(
   parameter int unsigned PERMS_PER_HALF = PERMUTATIONS_PER_HALF
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [KEY_PAIR_BITS-1:0]  csr_wdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // plain_word_a, plain_word_b, plain_word_c, plain_word_d
   input  logic [4*WORD_BITS-1:0]    req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // cipher_word_a, cipher_word_b, cipher_word_c, cipher_word_d
   output logic [4*WORD_BITS-1:0]    rsp_tdata
);

   localparam int unsigned HALF_ROUNDS = ROUNDS_PER_PERM * PERMS_PER_HALF;
   localparam int unsigned STAGES      = 2 * HALF_ROUNDS + 3;

   key_pair_type key_ff [KEY_PAIRS];
   block_type    round_key [3];
   block_type    pipe_data [STAGES+1];
   logic [STAGES:0] pipe_valid;
   logic [STAGES:0] pipe_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_PAIRS; i++) begin
            key_ff[i] <= '0;
         end
      end else if (csr_wr_en && (csr_index < CSR_INDEX_BITS'(KEY_PAIRS))) begin
         key_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         round_key[k].a = key_ff[2*k][WORD_BITS-1:0];
         round_key[k].b = key_ff[2*k][KEY_PAIR_BITS-1:WORD_BITS];
         round_key[k].c = key_ff[2*k+1][WORD_BITS-1:0];
         round_key[k].d = key_ff[2*k+1][KEY_PAIR_BITS-1:WORD_BITS];
      end
   end

   assign pipe_valid[0]      = req_tvalid;
   assign pipe_data[0]       = block_type'(req_tdata);
   assign req_tready         = pipe_ready[0];
   assign pipe_ready[STAGES] = rsp_tready;
   assign rsp_tvalid         = pipe_valid[STAGES];
   assign rsp_tdata          = pipe_data[STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      if (s == 0 || s == HALF_ROUNDS + 1 || s == STAGES - 1) begin : g_key
         arxbc_key_stage u_key (
            .clock     (clock),
            .reset     (reset),
            .round_key (round_key[(s == 0) ? 0 : ((s == STAGES - 1) ? 2 : 1)]),
            .in_valid  (pipe_valid[s]),
            .in_ready  (pipe_ready[s]),
            .in_data   (pipe_data[s]),
            .out_valid (pipe_valid[s+1]),
            .out_ready (pipe_ready[s+1]),
            .out_data  (pipe_data[s+1])
         );
      end else begin : g_round
         arxbc_round_stage #(
            .ROUND_SEL ((s <= HALF_ROUNDS) ? ((s - 1) % ROUNDS_PER_PERM)
                                           : ((s - HALF_ROUNDS - 2) % ROUNDS_PER_PERM))
         ) u_round (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (pipe_valid[s]),
            .in_ready  (pipe_ready[s]),
            .in_data   (pipe_data[s]),
            .out_valid (pipe_valid[s+1]),
            .out_ready (pipe_ready[s+1]),
            .out_data  (pipe_data[s+1])
         );
      end
   end

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_drain_open : assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request blocked while the result side drains");

   a_first_stage_loaded : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> pipe_valid[1])
      else $error("accepted request missing from the first stage");

endmodule

// ===== rtl/arxbc_key_stage.sv =====
// ----------------------------------------------------------------------------
// arxbc_key_stage
// pipeline stage that xors a 128-bit round key into the block
// ----------------------------------------------------------------------------
module arxbc_key_stage
   import arxbc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  block_type round_key,
   input  logic      in_valid,
   output logic      in_ready,
   input  block_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output block_type out_data
);

   logic      valid_ff;
   logic      valid_in;
   block_type data_ff;
   logic      load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= in_data ^ round_key;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/arxbc_round_stage.sv =====
// ----------------------------------------------------------------------------
// arxbc_round_stage
// pipeline stage holding one add-rotate-xor round of the permutation
// ----------------------------------------------------------------------------
module arxbc_round_stage
   import arxbc_pkg::*;
#(
   parameter int unsigned ROUND_SEL = 0
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  block_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output block_type out_data
);

   logic      valid_ff;
   logic      valid_in;
   block_type data_ff;
   logic      load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= arx_round(in_data, ROUND_SEL);
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
